>>> rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg: shared types and arithmetic for the Gear predictor-corrector
// Fixed-point widths, register indexes, stage words and the floor-scaled
// multiply and saturation helpers used by every pipeline section.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_STEP_DT         = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_STEP_SQ_HALF    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_STEP_CUBE_SIXTH = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_POS_GAIN        = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_VEL_GAIN        = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_JERK_GAIN       = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_VOLUME_FACTOR   = IDX_W'(6);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    word_t step_dt;
    word_t step_sq_half;
    word_t step_cube_sixth;
    word_t pos_gain;
    word_t vel_gain;
    word_t jerk_gain;
    word_t volume_factor;
  } cfg_t;

  typedef struct packed {
    logic  func;
    logic  active;
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
    word_t upd;
  } in_word_t;

  typedef struct packed {
    logic  func;
    logic  active;
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
    word_t upd;
    term_t m0;
    term_t m1;
    term_t m2;
    term_t m3;
    term_t m4;
    term_t m5;
  } prod_t;

  typedef struct packed {
    logic  func;
    logic  active;
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
    word_t target;
    word_t nvel;
    word_t nacc;
    sum_t  part_disp;
    term_t m2;
  } part_t;

  typedef struct packed {
    logic  corr;
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
    word_t res;
  } resid_t;

  typedef struct packed {
    logic  corr;
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
    word_t res;
    term_t gd;
    term_t gv;
    term_t gj;
  } gain_t;

  typedef struct packed {
    word_t disp;
    word_t vel;
    word_t acc;
    word_t jerk;
  } result_t;

  // Product scaled down by the fraction bits, rounded toward minus infinity.
  function automatic term_t fmul(input word_t a, input word_t b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return p[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic sum_t ext_w(input word_t v);
    return sum_t'(v);
  endfunction

  function automatic sum_t ext_t(input term_t v);
    return sum_t'(v);
  endfunction

  function automatic word_t sat(input sum_t v);
    if (&v[SUM_W-1:WORD_W-1] || ~|v[SUM_W-1:WORD_W-1]) begin
      return v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/gpc_front.sv
// ----------------------------------------------------------------------------
// gpc_front: input capture and first multiplier bank
// Registers the incoming word, then forms the six Taylor products, with the
// displacement times volume factor product as the first for a correct word.
// ----------------------------------------------------------------------------
module gpc_front import gpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_word,
  input  cfg_t     cfg,
  output logic     prod_valid,
  output prod_t    prod
);

  logic     a_valid_r;
  in_word_t a_r;
  logic     b_valid_r;
  prod_t    b_r;
  prod_t    b_nxt;

  always_comb begin
    b_nxt.func   = a_r.func;
    b_nxt.active = a_r.active;
    b_nxt.disp   = a_r.disp;
    b_nxt.vel    = a_r.vel;
    b_nxt.acc    = a_r.acc;
    b_nxt.jerk   = a_r.jerk;
    b_nxt.upd    = a_r.upd;
    b_nxt.m0     = a_r.func ? fmul(a_r.disp, cfg.volume_factor) : fmul(cfg.step_dt, a_r.vel);
    b_nxt.m1     = fmul(cfg.step_sq_half, a_r.acc);
    b_nxt.m2     = fmul(cfg.step_cube_sixth, a_r.jerk);
    b_nxt.m3     = fmul(cfg.step_dt, a_r.acc);
    b_nxt.m4     = fmul(cfg.step_sq_half, a_r.jerk);
    b_nxt.m5     = fmul(cfg.step_dt, a_r.jerk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      a_r <= in_word;
    end
    if (a_valid_r) begin
      b_r <= b_nxt;
    end
  end

  assign prod_valid = b_valid_r;
  assign prod       = b_r;

endmodule

>>> rtl/gpc_mid.sv
// ----------------------------------------------------------------------------
// gpc_mid: predictor sums and corrector residual
// Adds the Taylor terms over two stages for a predict word, and forms the
// saturated target and residual for a correct word.
// ----------------------------------------------------------------------------
module gpc_mid import gpc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   prod_valid,
  input  prod_t  prod,
  output logic   resid_valid,
  output resid_t resid
);

  logic   c_valid_r;
  part_t  c_r;
  part_t  c_nxt;
  logic   d_valid_r;
  resid_t d_r;
  resid_t d_nxt;

  always_comb begin
    c_nxt.func      = prod.func;
    c_nxt.active    = prod.active;
    c_nxt.disp      = prod.disp;
    c_nxt.vel       = prod.vel;
    c_nxt.acc       = prod.acc;
    c_nxt.jerk      = prod.jerk;
    c_nxt.target    = sat(ext_w(prod.upd) + ext_t(prod.m0));
    c_nxt.nvel      = sat(ext_w(prod.vel) + ext_t(prod.m3) + ext_t(prod.m4));
    c_nxt.nacc      = sat(ext_w(prod.acc) + ext_t(prod.m5));
    c_nxt.part_disp = ext_w(prod.disp) + ext_t(prod.m0) + ext_t(prod.m1);
    c_nxt.m2        = prod.m2;
  end

  always_comb begin
    d_nxt.corr = c_r.func & c_r.active;
    d_nxt.res  = sat(ext_w(c_r.acc) - ext_w(c_r.target));
    if (c_r.func) begin
      d_nxt.disp = c_r.disp;
      d_nxt.vel  = c_r.vel;
      d_nxt.acc  = c_r.acc;
      d_nxt.jerk = c_r.jerk;
    end else begin
      d_nxt.disp = sat(c_r.part_disp + ext_t(c_r.m2));
      d_nxt.vel  = c_r.nvel;
      d_nxt.acc  = c_r.nacc;
      d_nxt.jerk = c_r.jerk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      c_valid_r <= prod_valid;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      c_r <= c_nxt;
    end
    if (c_valid_r) begin
      d_r <= d_nxt;
    end
  end

  assign resid_valid = d_valid_r;
  assign resid       = d_r;

endmodule

>>> rtl/gpc_back.sv
// ----------------------------------------------------------------------------
// gpc_back: corrector gain multipliers and output stage
// Multiplies the residual by the three gains, then, for an active correct word,
// subtracts and saturates into the output register; other words pass unchanged.
// ----------------------------------------------------------------------------
module gpc_back import gpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    resid_valid,
  input  resid_t  resid,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t result
);

  logic    e_valid_r;
  gain_t   e_r;
  gain_t   e_nxt;
  logic    f_valid_r;
  result_t f_r;
  result_t f_nxt;

  always_comb begin
    e_nxt.corr = resid.corr;
    e_nxt.disp = resid.disp;
    e_nxt.vel  = resid.vel;
    e_nxt.acc  = resid.acc;
    e_nxt.jerk = resid.jerk;
    e_nxt.res  = resid.res;
    e_nxt.gd   = fmul(resid.res, cfg.pos_gain);
    e_nxt.gv   = fmul(resid.res, cfg.vel_gain);
    e_nxt.gj   = fmul(resid.res, cfg.jerk_gain);
  end

  always_comb begin
    if (e_r.corr) begin
      f_nxt.disp = sat(ext_w(e_r.disp) - ext_t(e_r.gd));
      f_nxt.vel  = sat(ext_w(e_r.vel) - ext_t(e_r.gv));
      f_nxt.acc  = sat(ext_w(e_r.acc) - ext_w(e_r.res));
      f_nxt.jerk = sat(ext_w(e_r.jerk) - ext_t(e_r.gj));
    end else begin
      f_nxt.disp = e_r.disp;
      f_nxt.vel  = e_r.vel;
      f_nxt.acc  = e_r.acc;
      f_nxt.jerk = e_r.jerk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      e_valid_r <= resid_valid;
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (resid_valid) begin
      e_r <= e_nxt;
    end
    if (e_valid_r) begin
      f_r <= f_nxt;
    end
  end

  assign res_valid = f_valid_r;
  assign result    = f_r;

endmodule

>>> rtl/gear_predictor_corrector_dof.sv
// ----------------------------------------------------------------------------
// gear_predictor_corrector_dof: fourth-order Gear predictor-corrector, one dof
// A word is accepted at a rising edge with start high and busy low; busy is
// always low, so a new word may be issued on every clock cycle.
// Each word carries one degree of freedom's displacement, velocity,
// acceleration and jerk plus the solved update and the active flag; in_func
// selects the predict step or the correct step.
// Six register stages: input capture, first multiplier bank, Taylor partial
// sums and target, final sums and residual, gain multipliers, output
// register. The result is shown on the out_ ports for one cycle with
// out_valid high. Throughput is one word per cycle; the stage count sets
// the latency.
// The receiver cannot hold results off, and the block needs no backpressure.
// The cfg_ port writes one register per edge with cfg_we high and should
// only be used while no word is in flight; unknown indexes are ignored.
// Reset clears the pipeline valid bits and all configuration registers.
// ----------------------------------------------------------------------------
module gear_predictor_corrector_dof import gpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [31:0]      in_disp_in,
  input  logic [31:0]      in_vel_in,
  input  logic [31:0]      in_acc_in,
  input  logic [31:0]      in_jerk_in,
  input  logic [31:0]      in_update_value,
  input  logic             in_active_dof,
  output logic             out_valid,
  output logic [31:0]      out_disp_out,
  output logic [31:0]      out_vel_out,
  output logic [31:0]      out_acc_out,
  output logic [31:0]      out_jerk_out,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  cfg_t     cfg_r;
  in_word_t in_word;
  logic     in_valid;
  logic     prod_valid;
  prod_t    prod;
  logic     resid_valid;
  resid_t   resid;
  logic     res_valid;
  result_t  result;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  always_comb begin
    in_word.func   = in_func;
    in_word.active = in_active_dof;
    in_word.disp   = in_disp_in;
    in_word.vel    = in_vel_in;
    in_word.acc    = in_acc_in;
    in_word.jerk   = in_jerk_in;
    in_word.upd    = in_update_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_DT:         cfg_r.step_dt         <= cfg_data;
        REG_STEP_SQ_HALF:    cfg_r.step_sq_half    <= cfg_data;
        REG_STEP_CUBE_SIXTH: cfg_r.step_cube_sixth <= cfg_data;
        REG_POS_GAIN:        cfg_r.pos_gain        <= cfg_data;
        REG_VEL_GAIN:        cfg_r.vel_gain        <= cfg_data;
        REG_JERK_GAIN:       cfg_r.jerk_gain       <= cfg_data;
        REG_VOLUME_FACTOR:   cfg_r.volume_factor   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .cfg        (cfg_r),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  gpc_mid u_mid (
    .clk         (clk),
    .rst_n       (rst_n),
    .prod_valid  (prod_valid),
    .prod        (prod),
    .resid_valid (resid_valid),
    .resid       (resid)
  );

  gpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .resid_valid (resid_valid),
    .resid       (resid),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .result      (result)
  );

  assign out_valid    = res_valid;
  assign out_disp_out = result.disp;
  assign out_vel_out  = result.vel;
  assign out_acc_out  = result.acc;
  assign out_jerk_out = result.jerk;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted word produced no result");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##6 !out_valid)
    else $error("result without an accepted word");

  a_inactive_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func && !in_active_dof) |-> ##6
      (out_disp_out == $past(in_disp_in, 6) && out_vel_out == $past(in_vel_in, 6) &&
       out_acc_out == $past(in_acc_in, 6) && out_jerk_out == $past(in_jerk_in, 6)))
    else $error("inactive correct word was modified");

  a_predict_jerk_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_func) |-> ##6 (out_jerk_out == $past(in_jerk_in, 6)))
    else $error("predict step changed jerk");

endmodule
